// ----- design/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HEAP_GRANULES = 8192;
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned IW    = $clog2(HEAP_GRANULES);
  localparam int unsigned SW    = IW + 1;
  localparam int unsigned OFF_W = 17;
  localparam int unsigned NW    = OFF_W - 3;
  localparam int unsigned BW    = OFF_W - 4;
  localparam int unsigned CW    = ((SW > NW) ? SW : NW) + 1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_NOTBLOCK = 2'd3;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  typedef struct packed {
    logic          start;
    logic          free;
    logic [IW-1:0] prev;
    logic [SW-1:0] size;
  } entry_t;

  typedef struct packed {
    logic size;
    logic flags;
    logic prev;
  } we_t;

endpackage

// ----- design/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a granule heap with coalescing on free.
//
//   channel | direction | word
//   in      | input     | mode, request_bytes, release_offset, release_is_null
//   out     | output    | status, data_offset
//
// Allocate: each walked block is read (S_ARD) and checked (S_AEV); a fit
// goes to S_OUT, through S_ANB and S_AAF if it splits, and the heap end gives
// no fit. Free: one table access per cycle. Heap reset: one table row per
// cycle over all HEAP_GRANULES rows (8192); after rst_ni the same clearing
// pass runs before the first word is taken. One result waits in the output
// register while the next word is worked on; a full register stalls the end.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [16:0] request_bytes_i,
  input  logic [16:0] release_offset_i,
  input  logic        release_is_null_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [16:0] data_offset_o
);

  localparam int unsigned IW = ffha_pkg::IW;
  localparam int unsigned SW = ffha_pkg::SW;
  localparam int unsigned CW = ffha_pkg::CW;
  localparam int unsigned XW = ffha_pkg::IW + ffha_pkg::BW;
  localparam logic [CW-1:0] HEAP = CW'(ffha_pkg::HEAP_GRANULES);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_ARD   = 5'd2;
  localparam logic [4:0] S_AEV   = 5'd3;
  localparam logic [4:0] S_ANB   = 5'd4;
  localparam logic [4:0] S_AAF   = 5'd5;
  localparam logic [4:0] S_FRDB  = 5'd6;
  localparam logic [4:0] S_FEVB  = 5'd7;
  localparam logic [4:0] S_FRDP  = 5'd8;
  localparam logic [4:0] S_FEVP  = 5'd9;
  localparam logic [4:0] S_FCLB  = 5'd10;
  localparam logic [4:0] S_FPNX  = 5'd11;
  localparam logic [4:0] S_FRDN  = 5'd12;
  localparam logic [4:0] S_FEVN  = 5'd13;
  localparam logic [4:0] S_FWBK  = 5'd14;
  localparam logic [4:0] S_FAFT  = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0]    state_q, state_d;
  logic [SW-1:0] clr_q, clr_d;
  logic          clr_item_q, clr_item_d;
  logic [SW-1:0] g_q, g_d;
  logic [SW-1:0] need_q, need_d;
  logic [IW-1:0] b_q, b_d;
  logic [SW-1:0] p_q, p_d;
  logic [SW-1:0] sz_q, sz_d;
  logic [SW-1:0] nx_q, nx_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [16:0]   res_off_q, res_off_d;
  logic          ovalid_q, ovalid_d;
  logic [1:0]    ost_q, ost_d;
  logic [16:0]   ooff_q, ooff_d;

  logic [IW-1:0]    addr;
  ffha_pkg::we_t    we;
  ffha_pkg::entry_t wd;
  ffha_pkg::entry_t rd;

  logic [CW-1:0] add_a, add_b, add_y;
  logic [CW-1:0] remain;
  logic [17:0]   req_up;
  logic [ffha_pkg::BW-1:0] b_short;
  logic [XW-1:0] b_ext;
  logic          in_acc;

  ffha_store u_store (
    .clk_i  (clk_i),
    .addr_i (addr),
    .we_i   (we),
    .wdata_i(wd),
    .rdata_o(rd)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_valid_o   = ovalid_q;
  assign status_o      = ost_q;
  assign data_offset_o = ooff_q;

  assign add_y   = add_a + add_b;
  assign remain  = CW'(rd.size) - CW'(need_q);
  assign req_up  = {1'b0, request_bytes_i} + 18'd15;
  assign b_short = release_offset_i[16:4] - ffha_pkg::BW'(1);
  assign b_ext   = XW'(b_short);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    clr_item_d = clr_item_q;
    g_d        = g_q;
    need_d     = need_q;
    b_d        = b_q;
    p_d        = p_q;
    sz_d       = sz_q;
    nx_d       = nx_q;
    res_st_d   = res_st_q;
    res_off_d  = res_off_q;
    ovalid_d   = ovalid_q;
    ost_d      = ost_q;
    ooff_d     = ooff_q;
    addr       = g_q[IW-1:0];
    we         = '0;
    wd         = '0;
    add_a      = CW'(g_q);
    add_b      = CW'(rd.size);

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_off_d = '0;
          g_d       = '0;
          unique case (mode_i)
            ffha_pkg::MODE_INIT: begin
              clr_d      = '0;
              clr_item_d = 1'b1;
              res_st_d   = ffha_pkg::ST_DONE;
              state_d    = S_CLR;
            end
            ffha_pkg::MODE_ALLOC: begin
              need_d  = SW'(req_up[17:4]) + SW'(1);
              state_d = S_ARD;
            end
            ffha_pkg::MODE_FREE: begin
              b_d     = b_ext[IW-1:0];
              state_d = S_FRDB;
              if (release_is_null_i) begin
                res_st_d = ffha_pkg::ST_IGNORED;
                state_d  = S_OUT;
              end else if (release_offset_i[3:0] != 4'd0 || release_offset_i[16:4] == '0 ||
                           CW'(b_ext) >= HEAP) begin
                res_st_d = ffha_pkg::ST_NOTBLOCK;
                state_d  = S_OUT;
              end
            end
            default: begin
              res_st_d = ffha_pkg::ST_IGNORED;
              state_d  = S_OUT;
            end
          endcase
        end
      end
      S_CLR: begin
        addr     = clr_q[IW-1:0];
        we       = '{size: 1'b1, flags: 1'b1, prev: 1'b1};
        if (clr_q == '0) begin
          wd.size  = SW'(ffha_pkg::HEAP_GRANULES);
          wd.start = 1'b1;
          wd.free  = 1'b1;
        end
        clr_d = clr_q + SW'(1);
        if (CW'(clr_q) == HEAP - CW'(1)) state_d = clr_item_q ? S_OUT : S_IDLE;
      end
      S_ARD: begin
        if (CW'(g_q) >= HEAP) begin
          res_st_d = ffha_pkg::ST_NOFIT;
          state_d  = S_OUT;
        end else begin
          state_d = S_AEV;
        end
      end
      S_AEV: begin
        if (rd.size == '0) begin
          res_st_d = ffha_pkg::ST_NOFIT;
          state_d  = S_OUT;
        end else if (rd.free && CW'(rd.size) >= CW'(need_q)) begin
          we.flags  = 1'b1;
          wd.start  = 1'b1;
          wd.free   = 1'b0;
          wd.size   = need_q;
          res_st_d  = ffha_pkg::ST_DONE;
          res_off_d = 17'({g_q + SW'(1), 4'b0000});
          nx_d      = g_q + need_q;
          sz_d      = remain[SW-1:0];
          p_d       = add_y[SW-1:0];
          if (remain > CW'(1)) begin
            we.size = 1'b1;
            state_d = S_ANB;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          g_d     = add_y[SW-1:0];
          state_d = S_ARD;
        end
      end
      S_ANB: begin
        addr     = nx_q[IW-1:0];
        we       = '{size: 1'b1, flags: 1'b1, prev: 1'b1};
        wd.size  = sz_q;
        wd.start = 1'b1;
        wd.free  = 1'b1;
        wd.prev  = g_q[IW-1:0];
        state_d  = S_AAF;
      end
      S_AAF: begin
        addr    = p_q[IW-1:0];
        wd.prev = nx_q[IW-1:0];
        we.prev = (CW'(p_q) < HEAP);
        state_d = S_OUT;
      end
      S_FRDB: begin
        addr    = b_q;
        state_d = S_FEVB;
      end
      S_FEVB: begin
        addr = b_q;
        if (!rd.start) begin
          res_st_d = ffha_pkg::ST_NOTBLOCK;
          state_d  = S_OUT;
        end else if (rd.free) begin
          res_st_d = ffha_pkg::ST_IGNORED;
          state_d  = S_OUT;
        end else begin
          we.flags = 1'b1;
          wd.start = 1'b1;
          wd.free  = 1'b1;
          res_st_d = ffha_pkg::ST_DONE;
          sz_d     = rd.size;
          g_d      = SW'(b_q);
          p_d      = SW'(rd.prev);
          state_d  = (b_q != '0) ? S_FRDP : S_FRDN;
        end
      end
      S_FRDP: begin
        addr    = p_q[IW-1:0];
        state_d = S_FEVP;
      end
      S_FEVP: begin
        addr  = p_q[IW-1:0];
        add_a = CW'(rd.size);
        add_b = CW'(sz_q);
        if (rd.start && rd.free) begin
          we.size = 1'b1;
          wd.size = add_y[SW-1:0];
          nx_d    = SW'(b_q) + sz_q;
          sz_d    = add_y[SW-1:0];
          g_d     = p_q;
          state_d = S_FCLB;
        end else begin
          state_d = S_FRDN;
        end
      end
      S_FCLB: begin
        addr     = b_q;
        we.flags = 1'b1;
        state_d  = S_FPNX;
      end
      S_FPNX: begin
        addr    = nx_q[IW-1:0];
        wd.prev = g_q[IW-1:0];
        we.prev = (CW'(nx_q) < HEAP);
        state_d = S_FRDN;
      end
      S_FRDN: begin
        add_b = CW'(sz_q);
        addr  = add_y[IW-1:0];
        nx_d  = add_y[SW-1:0];
        if (add_y > CW'(g_q) && add_y < HEAP) state_d = S_FEVN;
        else state_d = S_OUT;
      end
      S_FEVN: begin
        addr  = nx_q[IW-1:0];
        add_a = CW'(nx_q);
        if (rd.start && rd.free) begin
          we.flags = 1'b1;
          p_d      = add_y[SW-1:0];
          sz_d     = sz_q + rd.size;
          state_d  = S_FWBK;
        end else begin
          state_d = S_OUT;
        end
      end
      S_FWBK: begin
        we.size = 1'b1;
        wd.size = sz_q;
        state_d = S_FAFT;
      end
      S_FAFT: begin
        addr    = p_q[IW-1:0];
        wd.prev = g_q[IW-1:0];
        we.prev = (CW'(p_q) < HEAP);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ost_d    = res_st_q;
          ooff_d   = res_off_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      clr_item_q <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_item_q <= clr_item_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q       <= g_d;
    need_q    <= need_d;
    b_q       <= b_d;
    p_q       <= p_d;
    sz_q      <= sz_d;
    nx_q      <= nx_d;
    res_st_q  <= res_st_d;
    res_off_q <= res_off_d;
    ost_q     <= ost_d;
    ooff_q    <= ooff_d;
  end

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_i == ffha_pkg::MODE_INIT |=> state_q == S_CLR)
    else $error("heap reset did not start clearing pass");

  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result loaded outside output state");

  a_no_grant_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ffha_pkg::ST_DONE |-> data_offset_o == '0)
    else $error("offset given without a grant");

endmodule

// ----- design/ffha_store.sv -----
// ----------------------------------------------------------------------------
// ffha_store
// Block table: size, start/free flags and predecessor link per granule.
// ----------------------------------------------------------------------------
module ffha_store (
  input  logic                      clk_i,
  input  logic [ffha_pkg::IW-1:0]   addr_i,
  input  ffha_pkg::we_t             we_i,
  input  ffha_pkg::entry_t          wdata_i,
  output ffha_pkg::entry_t          rdata_o
);

  logic [ffha_pkg::SW-1:0] size_mem [ffha_pkg::HEAP_GRANULES];
  logic [1:0]              flag_mem [ffha_pkg::HEAP_GRANULES];
  logic [ffha_pkg::IW-1:0] prev_mem [ffha_pkg::HEAP_GRANULES];
  ffha_pkg::entry_t        rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i.size) size_mem[addr_i] <= wdata_i.size;
    if (we_i.flags) flag_mem[addr_i] <= {wdata_i.start, wdata_i.free};
    if (we_i.prev) prev_mem[addr_i] <= wdata_i.prev;
    rdata_q.size  <= size_mem[addr_i];
    rdata_q.start <= flag_mem[addr_i][1];
    rdata_q.free  <= flag_mem[addr_i][0];
    rdata_q.prev  <= prev_mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
